### src/tts_pkg.sv
// Package for the BER-TLV tag search block: payload structs, status codes
// and sizing constants. No dependencies.
`default_nettype none
package tts_pkg;

    localparam int LEN_BITS  = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_BAD_FORM  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LAST  = 2'd1;

    localparam logic [4:0] TAG_MORE_MARK = 5'h1F;
    localparam logic [7:0] LEN_LONG_1    = 8'h81;
    localparam logic [7:0] LEN_LONG_3    = 8'h83;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          value_byte;
        logic                value_valid;
        logic                search_done;
        logic [1:0]          status;
        logic [LEN_BITS-1:0] value_length;
    } out_item_t;

    typedef struct packed {
        logic [7:0] target_first_tag;
        logic [7:0] target_last_tag;
    } cfg_t;

endpackage
`default_nettype wire

### src/tts_parser.sv
// TLV walker: header decode, match and value streaming; one byte per cycle while step is high.
// Depends on tts_pkg.
`default_nettype none
module tts_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  tts_pkg::in_item_t     item,
    input  tts_pkg::cfg_t         cfg,
    output logic                  res_valid,
    output tts_pkg::out_item_t    res
);
    import tts_pkg::*;

    localparam logic [2:0] PH_TAG_FIRST = 3'd0;
    localparam logic [2:0] PH_TAG_MORE  = 3'd1;
    localparam logic [2:0] PH_LEN_FIRST = 3'd2;
    localparam logic [2:0] PH_LEN_MORE  = 3'd3;
    localparam logic [2:0] PH_VALUE     = 3'd4;
    localparam logic [2:0] PH_DONE      = 3'd5;

    logic [2:0]          phase_reg, phase_next;
    logic [7:0]          first_reg, first_next;
    logic [7:0]          last_tag_reg, last_tag_next;
    logic [1:0]          left_reg, left_next;
    logic [LEN_BITS-1:0] acc_reg, acc_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic                match_reg, match_next;

    logic [7:0]          b;
    logic                last;
    logic                hdr;
    logic [LEN_BITS-1:0] hdr_len;
    logic                hdr_match;
    logic [LEN_BITS-1:0] rem_dec;
    logic                emit;
    logic                done;
    logic [1:0]          st;
    logic [LEN_BITS-1:0] len;
    logic                vvalid;

    assign b    = item.data_byte;
    assign last = item.is_last;

    assign hdr_match = (first_reg == cfg.target_first_tag) &&
                       ((cfg.target_last_tag == 8'd0) ||
                        (last_tag_reg == cfg.target_last_tag));
    assign rem_dec = (rem_reg != '0) ? rem_reg - LEN_BITS'(1) : rem_reg;

    always_comb begin
        phase_next    = phase_reg;
        first_next    = first_reg;
        last_tag_next = last_tag_reg;
        left_next     = left_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        match_next    = match_reg;
        hdr           = 1'b0;
        hdr_len       = '0;
        emit          = 1'b0;
        done          = 1'b0;
        st            = ST_FOUND;
        len           = '0;
        vvalid        = 1'b0;

        unique case (phase_reg)
            PH_TAG_FIRST: begin
                first_next    = b;
                last_tag_next = 8'd0;
                phase_next    = (b[4:0] == TAG_MORE_MARK) ? PH_TAG_MORE : PH_LEN_FIRST;
                if (last) begin
                    emit = 1'b1; done = 1'b1; st = ST_TRUNCATED;
                end
            end
            PH_TAG_MORE: begin
                last_tag_next = b;
                if (!b[7]) begin
                    phase_next = PH_LEN_FIRST;
                end
                if (last) begin
                    emit = 1'b1; done = 1'b1; st = ST_TRUNCATED;
                end
            end
            PH_LEN_FIRST: begin
                if (!b[7]) begin
                    acc_next  = LEN_BITS'(b);
                    left_next = 2'd0;
                    hdr       = 1'b1;
                    hdr_len   = LEN_BITS'(b);
                end else if (b >= LEN_LONG_1 && b <= LEN_LONG_3) begin
                    left_next  = b[1:0];
                    acc_next   = '0;
                    phase_next = PH_LEN_MORE;
                    if (last) begin
                        emit = 1'b1; done = 1'b1; st = ST_TRUNCATED;
                    end
                end else begin
                    emit = 1'b1; done = 1'b1; st = ST_BAD_FORM;
                end
            end
            PH_LEN_MORE: begin
                acc_next  = {acc_reg[LEN_BITS-9:0], b};
                left_next = left_reg - 2'd1;
                if (left_reg == 2'd1) begin
                    hdr     = 1'b1;
                    hdr_len = {acc_reg[LEN_BITS-9:0], b};
                end else if (last) begin
                    emit = 1'b1; done = 1'b1; st = ST_TRUNCATED;
                end
            end
            PH_VALUE: begin
                rem_next = rem_dec;
                if (match_reg) begin
                    emit   = 1'b1;
                    vvalid = 1'b1;
                    if (rem_dec == '0) begin
                        done = 1'b1; st = ST_FOUND; len = acc_reg;
                    end else if (last) begin
                        done = 1'b1; st = ST_TRUNCATED; len = acc_reg;
                    end
                end else if (rem_dec == '0) begin
                    if (last) begin
                        emit = 1'b1; done = 1'b1; st = ST_NOT_FOUND;
                    end else begin
                        phase_next = PH_TAG_FIRST;
                    end
                end else if (last) begin
                    emit = 1'b1; done = 1'b1; st = ST_TRUNCATED;
                end
            end
            PH_DONE: begin
                if (last) begin
                    phase_next = PH_TAG_FIRST;
                end
            end
            default: begin
                phase_next = PH_TAG_FIRST;
            end
        endcase

        // header just completed: latch match and value count
        if (hdr) begin
            match_next = hdr_match;
            rem_next   = hdr_len;
            if (hdr_len == '0) begin
                if (hdr_match) begin
                    emit = 1'b1; done = 1'b1; st = ST_FOUND;
                end else if (last) begin
                    emit = 1'b1; done = 1'b1; st = ST_NOT_FOUND;
                end else begin
                    phase_next = PH_TAG_FIRST;
                end
            end else begin
                phase_next = PH_VALUE;
                if (last) begin
                    emit = 1'b1; done = 1'b1; st = ST_TRUNCATED;
                    len  = hdr_match ? hdr_len : '0;
                end
            end
        end

        if (done) begin
            phase_next = last ? PH_TAG_FIRST : PH_DONE;
        end
    end

    always_comb begin
        res_valid        = step && emit;
        res.value_byte   = vvalid ? b : 8'd0;
        res.value_valid  = vvalid;
        res.search_done  = done;
        res.status       = done ? st : ST_FOUND;
        res.value_length = done ? len : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TAG_FIRST;
            first_reg    <= 8'd0;
            last_tag_reg <= 8'd0;
            left_reg     <= 2'd0;
            acc_reg      <= '0;
            rem_reg      <= '0;
            match_reg    <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            first_reg    <= first_next;
            last_tag_reg <= last_tag_next;
            left_reg     <= left_next;
            acc_reg      <= acc_next;
            rem_reg      <= rem_next;
            match_reg    <= match_next;
        end
    end

endmodule
`default_nettype wire

### src/tts_out_skid.sv
// Result output register with one skid entry, so ready does not follow m_ready.
// Depends on tts_pkg.
`default_nettype none
module tts_out_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  tts_pkg::out_item_t    push_data,
    output logic                  can_take,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output tts_pkg::out_item_t    m_data
);
    import tts_pkg::*;

    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      pop;

    assign pop      = out_valid_reg && m_ready;
    assign can_take = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule
`default_nettype wire

### src/tlv_tag_search.sv
// Top level of the BER-TLV tag search: config registers, walker, output skid.
// A result is registered in the output stage before it shows on m_valid.
// Throughput: one byte per cycle; s_ready drops only while the skid entry holds.
// Reset (aresetn low, synchronous): walker waits for a first tag byte, both
// targets read zero, no result pending. Depends on tts_pkg, tts_parser, tts_out_skid.
`default_nettype none
module tlv_tag_search (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  tts_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output tts_pkg::out_item_t                   m_data,
    input  wire logic                            cfg_we,
    input  wire logic [tts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                      cfg_wdata
);
    import tts_pkg::*;

    cfg_t      cfg_reg;
    logic      step;
    logic      res_valid;
    out_item_t res;
    logic      can_take;

    // Target tag registers; writes to unused indexes drop silently.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TARGET_FIRST: cfg_reg.target_first_tag <= cfg_wdata;
                CFG_TARGET_LAST:  cfg_reg.target_last_tag  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Accept a transaction whenever the skid entry is free; every byte
    // advances the walker, and only bytes that produce a result push.
    assign s_ready = can_take;
    assign step    = s_valid && s_ready;

    tts_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (s_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold results in the output register; spill into the skid on a stall.
    tts_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .can_take  (can_take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for tlv_tag_search: streams BER-TLV byte buffers,
// predicts the value bytes and the done status of each buffer, and checks
// every result transaction in order. Depends on tts_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import tts_pkg::*;

    localparam int CLK_HALF          = 4;
    localparam int RESET_CYCLES      = 4;
    localparam int CYCLE_LIMIT       = 200000;
    // Settling time after the drain, for the registered output stage.
    localparam int QUIET_CYCLES      = 4;
    localparam int ITEMS_PER_SETTING = 10;
    localparam int SETTINGS_PER_MODE = 2;
    localparam int IDLE_MODES        = 4;

    localparam logic [7:0] LEN_SHORT_LIMIT = 8'h80;
    localparam logic [7:0] BYTE_MAX        = 8'hFF;
    localparam logic [7:0] BYTE_MIN        = 8'h00;

    // The index port is wider than the register file: these land nowhere.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum logic [2:0] {
        WALK_TAG_FIRST,
        WALK_TAG_MORE,
        WALK_LEN_FIRST,
        WALK_LEN_MORE,
        WALK_VALUE,
        WALK_DONE
    } walk_phase_t;

    // DUT-facing signals; the inputs are at known values from time zero.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;

    // Stimulus bookkeeping.
    in_item_t    bytes_to_send[$];
    out_item_t   search_results_due[$];
    logic [7:0]  frame_bytes[$];
    int unsigned queued_count   = 0;
    int unsigned taken_count    = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Predictor copy of the targets and of the walker state.
    logic [7:0]          tgt_first     = '0;
    logic [7:0]          tgt_last      = '0;
    walk_phase_t         walk_phase    = WALK_TAG_FIRST;
    logic [7:0]          seen_first    = '0;
    logic [7:0]          seen_last     = '0;
    logic [1:0]          len_left      = '0;
    logic [LEN_BITS-1:0] len_acc       = '0;
    logic [LEN_BITS-1:0] value_left    = '0;
    logic                tag_hit       = 1'b0;

    tlv_tag_search DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queue one expected result; a done result closes the buffer, and the
    // walker either waits for the end flag or starts over right away.
    task automatic post_result(input logic valid, input logic [7:0] vbyte,
                               input logic done, input logic [1:0] stat,
                               input logic [LEN_BITS-1:0] len, input logic lst);
        out_item_t r;
        r.value_byte   = valid ? vbyte : '0;
        r.value_valid  = valid;
        r.search_done  = done;
        r.status       = done ? stat : '0;
        r.value_length = done ? len : '0;
        search_results_due = {search_results_due, r};
        if (done)
            walk_phase = lst ? WALK_TAG_FIRST : WALK_DONE;
    endtask

    // Tag and length are in: decide the match and enter the value.
    task automatic close_header(input logic lst);
        if (tgt_last == '0)
            tag_hit = (seen_first == tgt_first);
        else
            tag_hit = (seen_first == tgt_first) && (seen_last == tgt_last);
        value_left = len_acc;
        if (len_acc == '0) begin
            if (tag_hit)
                post_result(1'b0, '0, 1'b1, ST_FOUND, '0, lst);
            else if (lst)
                post_result(1'b0, '0, 1'b1, ST_NOT_FOUND, '0, lst);
            else
                walk_phase = WALK_TAG_FIRST;
        end else begin
            walk_phase = WALK_VALUE;
            if (lst)
                post_result(1'b0, '0, 1'b1, ST_TRUNCATED, tag_hit ? len_acc : '0, lst);
        end
    endtask

    // Advance the walker by one accepted byte.
    task automatic walk_tlv_byte(input in_item_t it);
        logic [7:0] b;
        logic       lst;
        b   = it.data_byte;
        lst = it.is_last;
        case (walk_phase)
            WALK_TAG_FIRST: begin
                seen_first = b;
                seen_last  = '0;
                walk_phase = (b[4:0] == TAG_MORE_MARK) ? WALK_TAG_MORE : WALK_LEN_FIRST;
                if (lst)
                    post_result(1'b0, '0, 1'b1, ST_TRUNCATED, '0, lst);
            end
            WALK_TAG_MORE: begin
                seen_last = b;
                if (!b[7])
                    walk_phase = WALK_LEN_FIRST;
                if (lst)
                    post_result(1'b0, '0, 1'b1, ST_TRUNCATED, '0, lst);
            end
            WALK_LEN_FIRST: begin
                if (b < LEN_SHORT_LIMIT) begin
                    len_acc  = LEN_BITS'(b);
                    len_left = '0;
                    close_header(lst);
                end else if (b >= LEN_LONG_1 && b <= LEN_LONG_3) begin
                    len_left   = b[1:0];
                    len_acc    = '0;
                    walk_phase = WALK_LEN_MORE;
                    if (lst)
                        post_result(1'b0, '0, 1'b1, ST_TRUNCATED, '0, lst);
                end else begin
                    post_result(1'b0, '0, 1'b1, ST_BAD_FORM, '0, lst);
                end
            end
            WALK_LEN_MORE: begin
                len_acc = {len_acc[LEN_BITS-9:0], b};
                if (len_left != '0)
                    len_left = len_left - 2'd1;
                if (len_left == '0)
                    close_header(lst);
                else if (lst)
                    post_result(1'b0, '0, 1'b1, ST_TRUNCATED, '0, lst);
            end
            WALK_VALUE: begin
                if (value_left != '0)
                    value_left = value_left - LEN_BITS'(1);
                if (tag_hit) begin
                    if (value_left == '0)
                        post_result(1'b1, b, 1'b1, ST_FOUND, len_acc, lst);
                    else if (lst)
                        post_result(1'b1, b, 1'b1, ST_TRUNCATED, len_acc, lst);
                    else
                        post_result(1'b1, b, 1'b0, ST_FOUND, '0, lst);
                end else if (value_left == '0) begin
                    if (lst)
                        post_result(1'b0, '0, 1'b1, ST_NOT_FOUND, '0, lst);
                    else
                        walk_phase = WALK_TAG_FIRST;
                end else if (lst) begin
                    post_result(1'b0, '0, 1'b1, ST_TRUNCATED, '0, lst);
                end
            end
            default: begin
                // Search is over: drop bytes until the buffer ends.
                if (lst)
                    walk_phase = WALK_TAG_FIRST;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued bytes, predict on each accepted transaction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                walk_tlv_byte(s_data);
                taken_count++;
            end
            // Hold the payload while a transaction is stalled; otherwise
            // load the next byte or drop s_valid.
            if (!s_valid || s_ready) begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= bytes_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: match each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [LEN_BITS-1:0] want,
                               input logic [LEN_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (search_results_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, m_data);
                error_count++;
            end else begin
                want = search_results_due.pop_front();
                check_field("value_byte", LEN_BITS'(want.value_byte),
                            LEN_BITS'(m_data.value_byte));
                check_field("value_valid", LEN_BITS'(want.value_valid),
                            LEN_BITS'(m_data.value_valid));
                check_field("search_done", LEN_BITS'(want.search_done),
                            LEN_BITS'(m_data.search_done));
                check_field("status", LEN_BITS'(want.status),
                            LEN_BITS'(m_data.status));
                check_field("value_length", want.value_length, m_data.value_length);
            end
        end
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Append one byte to the buffer under construction.
    task automatic append_byte(input logic [7:0] v);
        frame_bytes = {frame_bytes, v};
    endtask

    // Write one register and mirror it in the predictor; call only when idle.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_TARGET_FIRST: tgt_first = val;
            CFG_TARGET_LAST:  tgt_last  = val;
            default:          ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Hold off until every byte is in and every prediction has come back,
    // then let the walker settle on bytes that produce no result.
    task automatic wait_idle();
        while (taken_count != queued_count || search_results_due.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Queue frame_bytes as one buffer, flagging its final byte.
    task automatic send_frame();
        in_item_t it;
        int unsigned idx;
        for (idx = 0; idx < frame_bytes.size(); idx++) begin
            it.data_byte = frame_bytes[idx];
            it.is_last   = (idx == frame_bytes.size() - 1);
            bytes_to_send = {bytes_to_send, it};
            queued_count++;
        end
    endtask

    // Mostly short values; a few long ones, and huge lengths only where the
    // record may close the buffer.
    function automatic int unsigned pick_length(input bit allow_huge);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(4);
        if (r < 88)
            return $urandom_range(20, 5);
        if (r < 92)
            return $urandom_range(140, 100);
        if (allow_huge)
            return (r < 96) ? 24'hFFFFFF : $urandom_range(24'hFFFFFF, 256);
        return $urandom_range(8);
    endfunction

    // Append one record: tag bytes, then a length in a random legal form and the value, or an illegal length byte.
    task automatic add_record(input bit want_match, input bit bad_len,
                              input int unsigned vlen);
        logic [7:0]  t0;
        int unsigned need;
        int unsigned form;
        int unsigned nval;
        int unsigned idx;
        t0 = want_match ? tgt_first : 8'($urandom_range(255));
        append_byte(t0);
        if (t0[4:0] == TAG_MORE_MARK) begin
            repeat ($urandom_range(2))
                append_byte({1'b1, 7'($urandom_range(127))});
            if (want_match && !tgt_last[7] && $urandom_range(7) != 0)
                append_byte(tgt_last);
            else
                append_byte({1'b0, 7'($urandom_range(127))});
        end
        if (bad_len) begin
            if ($urandom_range(1) == 0)
                append_byte(LEN_SHORT_LIMIT);
            else
                append_byte(8'($urandom_range(BYTE_MAX, LEN_LONG_3 + 1)));
            return;
        end
        need = (vlen > 16'hFFFF) ? 3 : (vlen > 8'hFF) ? 2 : (vlen >= LEN_SHORT_LIMIT) ? 1 : 0;
        form = (need == 0 && $urandom_range(1) == 0) ? 0 : $urandom_range(3, need);
        if (form == 0) begin
            append_byte(8'(vlen));
        end else begin
            append_byte(LEN_SHORT_LIMIT | 8'(form));
            for (idx = form; idx > 0; idx--)
                append_byte(8'(vlen >> (8 * (idx - 1))));
        end
        // Huge values are cut short: the buffer ends inside them.
        nval = (vlen > 255) ? $urandom_range(3) : vlen;
        repeat (nval) append_byte(8'($urandom_range(255)));
    endtask

    // One random buffer: mostly well-formed records, some cut short, some
    // with an illegal length byte, a few pure noise.
    task automatic build_buffer();
        int unsigned kind;
        int unsigned nrec;
        int unsigned cut;
        int unsigned idx;
        frame_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 6) begin
            repeat ($urandom_range(6, 1)) append_byte(8'($urandom_range(255)));
        end else begin
            nrec = $urandom_range(4, 1);
            for (idx = 0; idx < nrec; idx++)
                add_record($urandom_range(2) == 0, (kind < 16) && (idx == nrec - 1),
                           pick_length(idx == nrec - 1));
            if (kind >= 16 && kind < 32) begin
                cut = $urandom_range(frame_bytes.size() - 1, 1);
                frame_bytes = frame_bytes[0:cut-1];
            end
        end
        send_frame();
    endtask

    // Pick targets: fixed corners first, then a mix of one-byte and
    // multi-byte searches.
    task automatic choose_targets(input int unsigned k, output logic [7:0] f,
                                  output logic [7:0] l);
        case (k)
            0: begin f = BYTE_MIN; l = BYTE_MIN; end
            1: begin f = BYTE_MAX; l = BYTE_MAX; end
            2: begin f = BYTE_MAX; l = BYTE_MIN; end
            default: begin
                if ($urandom_range(1) == 0) begin
                    f = 8'($urandom_range(255));
                    if (f[4:0] == TAG_MORE_MARK)
                        f[0] = 1'b0;
                    l = BYTE_MIN;
                end else begin
                    f = 8'($urandom_range(255)) | {3'b000, TAG_MORE_MARK};
                    l = ($urandom_range(3) == 0) ? BYTE_MIN : {1'b0, 7'($urandom_range(127))};
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  f;
        logic [7:0]  l;
        int unsigned mode;
        int unsigned setting;
        int unsigned start;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Spare indexes must leave the targets alone.
        write_cfg(CFG_TARGET_FIRST, 8'h01);
        write_cfg(CFG_TARGET_LAST, BYTE_MIN);
        write_cfg(CFG_SPARE_LO, BYTE_MAX);
        write_cfg(CFG_SPARE_HI, 8'h02);

        // Directed buffers, searching for one-byte tag 01.
        // Zero-length match ends at once with found.
        frame_bytes = '{8'h01, 8'h00};
        send_frame();
        // Skip a non-matching record, then the match's last byte carries done.
        frame_bytes = '{8'h02, 8'h01, 8'hFF, 8'h01, 8'h01, 8'h00};
        send_frame();
        // Buffer ends right after a non-matching record.
        frame_bytes = '{8'h02, 8'h00};
        send_frame();
        // Length byte 0x80 mid-buffer; the trailing byte is dropped.
        frame_bytes = '{8'h01, LEN_SHORT_LIMIT, BYTE_MAX};
        send_frame();
        // Illegal long form on the last byte.
        frame_bytes = '{8'h01, 8'h84};
        send_frame();
        // Buffer ends inside a multi-byte tag.
        frame_bytes = '{8'h1F};
        send_frame();
        // Longest length, cut inside the value.
        frame_bytes = '{8'h01, LEN_LONG_3, BYTE_MAX, BYTE_MAX, BYTE_MAX, 8'hAA, 8'h55};
        send_frame();
        // Buffer ends inside a long-form length.
        frame_bytes = '{8'h01, 8'h82};
        send_frame();

        // Random part: four idle modes, two target settings in each. Every
        // setting change waits for the block to drain, so the sender pauses
        // until all outstanding results are back.
        for (mode = 0; mode < IDLE_MODES; mode++) begin
            for (setting = 0; setting < SETTINGS_PER_MODE; setting++) begin
                wait_idle();
                case (mode)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                    default: begin send_idle_pct = 17; recv_stall_pct = 17; end
                endcase
                choose_targets(mode * SETTINGS_PER_MODE + setting, f, l);
                write_cfg(CFG_TARGET_FIRST, f);
                write_cfg(CFG_TARGET_LAST, l);
                start = queued_count;
                while (queued_count - start < ITEMS_PER_SETTING)
                    build_buffer();
            end
        end

        // Drain, then allow for any late stray result.
        wait_idle();
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (error_count == 0 && search_results_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
src/tts_pkg.sv
src/tts_parser.sv
src/tts_out_skid.sv
src/tlv_tag_search.sv
verif/tb.sv
